// ----- design/pdr_pkg.sv -----
// Shared constants and types for the pinhole distortion residual pipeline.
`default_nettype none

package pdr_pkg;

   // Register indexes of the configuration port
   localparam logic [2:0] CSR_FOCAL_X    = 3'd0;
   localparam logic [2:0] CSR_FOCAL_Y    = 3'd1;
   localparam logic [2:0] CSR_CENTER_X   = 3'd2;
   localparam logic [2:0] CSR_CENTER_Y   = 3'd3;
   localparam logic [2:0] CSR_RADIAL_1   = 3'd4;
   localparam logic [2:0] CSR_RADIAL_2   = 3'd5;
   localparam logic [2:0] CSR_RADIAL_3   = 3'd6;
   localparam logic [2:0] CSR_TANGENTIAL = 3'd7;

   localparam logic [30:0] FOCAL_RST    = 31'd28496947;
   localparam logic [30:0] CENTER_X_RST = 31'd75497472;
   localparam logic [30:0] CENTER_Y_RST = 31'd42467328;

   localparam logic signed [29:0] UNIT_ONE = 30'sd268435456;   // 1.0 in Q.28
   localparam logic signed [37:0] FAC_ONE  = 38'sd268435456;
   localparam logic signed [48:0] PIX_FAR  = 49'sd1099511627776; // beyond any range check
   localparam logic signed [39:0] D_LIMIT  = 40'sd2147483648;    // 8.0 in Q.28
   localparam logic signed [39:0] RES_MAX  = 40'sd2147483647;
   localparam logic signed [39:0] RES_MIN  = -40'sd2147483648;

   // Pipeline stage positions
   localparam int unsigned DIV1_STEPS  = 34;
   localparam int unsigned DIV2_STEPS  = 29;
   localparam int unsigned ST_DIV1     = 3;
   localparam int unsigned ST_PIX      = ST_DIV1 + DIV1_STEPS + 1;
   localparam int unsigned ST_NORM     = ST_PIX + 1;
   localparam int unsigned ST_UNIT     = ST_NORM + DIV2_STEPS + 1;
   localparam int unsigned ST_CLAMP_D  = ST_UNIT + 11;
   localparam int unsigned ST_OUT      = ST_CLAMP_D + 3;
   localparam int unsigned NUM_STAGES  = ST_OUT + 1;
   localparam int unsigned U_DELAY     = 8;
   localparam int unsigned T_DELAY     = 4;

   typedef struct packed {
      logic signed [31:0] obs_u;
      logic signed [31:0] obs_v;
      logic               depth_zero;
      logic               sat;
   } side_type;

endpackage

`default_nettype wire

// ----- design/pinhole_distortion_residual_top.sv -----
// Pinhole projection with radial/tangential distortion, residual against observed pixel.
// One word per cycle sustained while the rsp word is taken without a wait.
// This rests on the fully pipelined dividers: 34 one-bit stages for the
// projection divide and 29 for the normalising divide, one quotient bit per stage.
// The whole pipeline advances together and holds while the rsp word waits.
// Synchronous reset clears all stage valid bits and loads the register defaults.
`default_nettype none

module pinhole_distortion_residual_top (
   input  wire          clock,
   input  wire          reset,
   input  wire          req_tvalid,
   output logic         req_tready,
   input  wire  [159:0] req_tdata,   // point_x, point_y, point_z, observed_u, observed_v
   output logic         rsp_tvalid,
   input  wire          rsp_tready,
   output logic [63:0]  rsp_tdata,   // residual_u, residual_v
   output logic [1:0]   rsp_tuser,   // depth_zero, saturated
   input  wire          csr_we,
   input  wire  [2:0]   csr_index,
   input  wire  [63:0]  csr_wdata
);

   localparam int unsigned NS  = pdr_pkg::NUM_STAGES;
   localparam int unsigned D1  = pdr_pkg::DIV1_STEPS;
   localparam int unsigned D2  = pdr_pkg::DIV2_STEPS;

   // ---------------- configuration registers ----------------
   logic        [30:0] focal_ff  [2];
   logic        [30:0] center_ff [2];
   logic signed [31:0] k1_ff, k2_ff, k3_ff, p1_ff, p2_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         focal_ff[0]  <= pdr_pkg::FOCAL_RST;
         focal_ff[1]  <= pdr_pkg::FOCAL_RST;
         center_ff[0] <= pdr_pkg::CENTER_X_RST;
         center_ff[1] <= pdr_pkg::CENTER_Y_RST;
         k1_ff        <= '0;
         k2_ff        <= '0;
         k3_ff        <= '0;
         p1_ff        <= '0;
         p2_ff        <= '0;
      end else if (csr_we) begin
         unique case (csr_index)
            pdr_pkg::CSR_FOCAL_X:    focal_ff[0]  <= csr_wdata[30:0];
            pdr_pkg::CSR_FOCAL_Y:    focal_ff[1]  <= csr_wdata[30:0];
            pdr_pkg::CSR_CENTER_X:   center_ff[0] <= csr_wdata[30:0];
            pdr_pkg::CSR_CENTER_Y:   center_ff[1] <= csr_wdata[30:0];
            pdr_pkg::CSR_RADIAL_1:   k1_ff        <= $signed(csr_wdata[31:0]);
            pdr_pkg::CSR_RADIAL_2:   k2_ff        <= $signed(csr_wdata[31:0]);
            pdr_pkg::CSR_RADIAL_3:   k3_ff        <= $signed(csr_wdata[31:0]);
            pdr_pkg::CSR_TANGENTIAL: begin
               p1_ff <= $signed(csr_wdata[31:0]);
               p2_ff <= $signed(csr_wdata[63:32]);
            end
            default: ;
         endcase
      end
   end

   // ---------------- pipeline control ----------------
   logic [NS-1:0]     vld_ff;
   pdr_pkg::side_type side_ff [NS];
   pdr_pkg::side_type side_in [NS];
   logic              en;
   logic              norm_sat, d_sat, r_sat;

   assign en         = !vld_ff[pdr_pkg::ST_OUT] || rsp_tready;
   assign req_tready = en;
   assign rsp_tvalid = vld_ff[pdr_pkg::ST_OUT];

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (en) begin
         vld_ff <= {vld_ff[NS-2:0], req_tvalid};
      end
   end

   always_comb begin
      side_in[0].obs_u      = $signed(req_tdata[127:96]);
      side_in[0].obs_v      = $signed(req_tdata[159:128]);
      side_in[0].depth_zero = (req_tdata[95:64] == 32'd0);
      side_in[0].sat        = 1'b0;
      for (int i = 1; i < NS; i++) begin
         side_in[i] = side_ff[i-1];
      end
      side_in[pdr_pkg::ST_NORM].sat    = side_ff[pdr_pkg::ST_NORM-1].sat | norm_sat;
      side_in[pdr_pkg::ST_CLAMP_D].sat = side_ff[pdr_pkg::ST_CLAMP_D-1].sat | d_sat;
      side_in[pdr_pkg::ST_OUT].sat     = side_ff[pdr_pkg::ST_OUT-1].sat | r_sat;
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int i = 0; i < NS; i++) begin
            side_ff[i] <= side_in[i];
         end
      end
   end

   // ---------------- projection numerator ----------------
   logic signed [31:0] in_p_ff [2];
   logic signed [31:0] in_z_ff, z1_ff, z2_ff;
   logic signed [63:0] cz_ff [2];
   logic signed [63:0] fp_ff [2];
   logic signed [63:0] num_ff [2];

   always_ff @(posedge clock) begin
      if (en) begin
         in_p_ff[0] <= $signed(req_tdata[31:0]);
         in_p_ff[1] <= $signed(req_tdata[63:32]);
         in_z_ff    <= $signed(req_tdata[95:64]);
         z1_ff      <= in_z_ff;
         z2_ff      <= z1_ff;
         for (int a = 0; a < 2; a++) begin
            cz_ff[a]  <= $signed({1'b0, center_ff[a]}) * in_z_ff;
            fp_ff[a]  <= $signed({1'b0, focal_ff[a]}) * in_p_ff[a];
            num_ff[a] <= cz_ff[a] + fp_ff[a];
         end
      end
   end

   // ---------------- projection divider, one quotient bit per stage ----------------
   logic        [31:0] d1_rem_ff  [D1+1][2];
   logic        [33:0] d1_low_ff  [D1+1][2];
   logic        [33:0] d1_quo_ff  [D1+1][2];
   logic               d1_neg_ff  [D1+1][2];
   logic               d1_big_ff  [D1+1][2];
   logic signed [47:0] d1_zpix_ff [D1+1][2];
   logic        [31:0] d1_div_ff  [D1+1];

   logic        [31:0] d1_rem_in  [D1+1][2];
   logic        [33:0] d1_low_in  [D1+1][2];
   logic        [33:0] d1_quo_in  [D1+1][2];
   logic        [31:0] z_abs;
   logic        [63:0] n_abs [2];

   always_comb begin
      logic [32:0] trial;
      logic        ge;
      z_abs = z2_ff[31] ? 32'(-z2_ff) : 32'(z2_ff);
      for (int a = 0; a < 2; a++) begin
         n_abs[a]        = num_ff[a][63] ? 64'(-num_ff[a]) : 64'(num_ff[a]);
         d1_rem_in[0][a] = {3'd0, n_abs[a][62:34]};
         d1_low_in[0][a] = n_abs[a][33:0];
         d1_quo_in[0][a] = '0;
      end
      for (int k = 0; k < D1; k++) begin
         for (int a = 0; a < 2; a++) begin
            trial = {d1_rem_ff[k][a], d1_low_ff[k][a][33]};
            ge    = (trial >= {1'b0, d1_div_ff[k]});
            d1_rem_in[k+1][a] = ge ? 32'(trial - {1'b0, d1_div_ff[k]}) : trial[31:0];
            d1_low_in[k+1][a] = {d1_low_ff[k][a][32:0], 1'b0};
            d1_quo_in[k+1][a] = {d1_quo_ff[k][a][32:0], ge};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         d1_div_ff[0] <= z_abs;
         for (int a = 0; a < 2; a++) begin
            d1_neg_ff[0][a]  <= num_ff[a][63] ^ z2_ff[31];
            // quotient would need more than 34 bits: far outside any pixel range
            d1_big_ff[0][a]  <= ({3'd0, n_abs[a][62:34]} >= z_abs);
            d1_zpix_ff[0][a] <= num_ff[a][63:16];
         end
         for (int k = 0; k <= D1; k++) begin
            for (int a = 0; a < 2; a++) begin
               d1_rem_ff[k][a] <= d1_rem_in[k][a];
               d1_low_ff[k][a] <= d1_low_in[k][a];
               d1_quo_ff[k][a] <= d1_quo_in[k][a];
            end
         end
         for (int k = 1; k <= D1; k++) begin
            d1_div_ff[k] <= d1_div_ff[k-1];
            for (int a = 0; a < 2; a++) begin
               d1_neg_ff[k][a]  <= d1_neg_ff[k-1][a];
               d1_big_ff[k][a]  <= d1_big_ff[k-1][a];
               d1_zpix_ff[k][a] <= d1_zpix_ff[k-1][a];
            end
         end
      end
   end

   // ---------------- projected pixel ----------------
   logic signed [48:0] pix_ff [2];
   logic signed [48:0] pix_in [2];
   logic signed [48:0] q_ext  [2];

   always_comb begin
      for (int a = 0; a < 2; a++) begin
         q_ext[a] = $signed({15'd0, d1_quo_ff[D1][a]});
         if (side_ff[pdr_pkg::ST_PIX-1].depth_zero) begin
            pix_in[a] = 49'(d1_zpix_ff[D1][a]);
         end else if (d1_big_ff[D1][a]) begin
            pix_in[a] = d1_neg_ff[D1][a] ? -pdr_pkg::PIX_FAR : pdr_pkg::PIX_FAR;
         end else begin
            pix_in[a] = d1_neg_ff[D1][a] ? -q_ext[a] : q_ext[a];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         pix_ff <= pix_in;
      end
   end

   // ---------------- normalising divider: (pix - c) * 2^27 / c ----------------
   logic        [30:0] d2_rem_ff [D2+1][2];
   logic        [28:0] d2_low_ff [D2+1][2];
   logic        [28:0] d2_quo_ff [D2+1][2];
   logic               d2_neg_ff [D2+1][2];
   logic               d2_hi_ff  [D2+1][2];
   logic               d2_lo_ff  [D2+1][2];

   logic        [30:0] d2_rem_in [D2+1][2];
   logic        [28:0] d2_low_in [D2+1][2];
   logic        [28:0] d2_quo_in [D2+1][2];
   logic signed [48:0] c_ext [2];
   logic signed [48:0] off   [2];
   logic        [48:0] off_abs [2];
   logic               n_hi [2];
   logic               n_lo [2];

   always_comb begin
      logic [31:0] trial;
      logic        ge;
      for (int a = 0; a < 2; a++) begin
         c_ext[a]   = $signed({18'd0, center_ff[a]});
         n_hi[a]    = pix_ff[a] > (c_ext[a] + (c_ext[a] <<< 1));
         n_lo[a]    = pix_ff[a] < -c_ext[a];
         off[a]     = pix_ff[a] - c_ext[a];
         off_abs[a] = off[a][48] ? 49'(-off[a]) : 49'(off[a]);
         d2_rem_in[0][a] = {1'b0, off_abs[a][31:2]};
         d2_low_in[0][a] = {off_abs[a][1:0], 27'd0};
         d2_quo_in[0][a] = '0;
      end
      norm_sat = n_hi[0] | n_lo[0] | n_hi[1] | n_lo[1];
      for (int k = 0; k < D2; k++) begin
         for (int a = 0; a < 2; a++) begin
            trial = {d2_rem_ff[k][a], d2_low_ff[k][a][28]};
            ge    = (trial >= {1'b0, center_ff[a]});
            d2_rem_in[k+1][a] = ge ? 31'(trial - {1'b0, center_ff[a]}) : trial[30:0];
            d2_low_in[k+1][a] = {d2_low_ff[k][a][27:0], 1'b0};
            d2_quo_in[k+1][a] = {d2_quo_ff[k][a][27:0], ge};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int a = 0; a < 2; a++) begin
            d2_neg_ff[0][a] <= off[a][48];
            d2_hi_ff[0][a]  <= n_hi[a];
            d2_lo_ff[0][a]  <= n_lo[a];
         end
         for (int k = 0; k <= D2; k++) begin
            for (int a = 0; a < 2; a++) begin
               d2_rem_ff[k][a] <= d2_rem_in[k][a];
               d2_low_ff[k][a] <= d2_low_in[k][a];
               d2_quo_ff[k][a] <= d2_quo_in[k][a];
            end
         end
         for (int k = 1; k <= D2; k++) begin
            for (int a = 0; a < 2; a++) begin
               d2_neg_ff[k][a] <= d2_neg_ff[k-1][a];
               d2_hi_ff[k][a]  <= d2_hi_ff[k-1][a];
               d2_lo_ff[k][a]  <= d2_lo_ff[k-1][a];
            end
         end
      end
   end

   // ---------------- normalised coordinates U, V (Q.28) ----------------
   logic signed [29:0] ucoord_ff [pdr_pkg::U_DELAY+1][2];
   logic signed [29:0] ucoord_in [2];
   logic signed [29:0] uq_ext [2];

   always_comb begin
      for (int a = 0; a < 2; a++) begin
         uq_ext[a] = $signed({1'b0, d2_quo_ff[D2][a]});
         if (d2_hi_ff[D2][a]) begin
            ucoord_in[a] = pdr_pkg::UNIT_ONE;
         end else if (d2_lo_ff[D2][a]) begin
            ucoord_in[a] = -pdr_pkg::UNIT_ONE;
         end else if (center_ff[a] == 31'd0) begin
            ucoord_in[a] = '0;
         end else begin
            ucoord_in[a] = d2_neg_ff[D2][a] ? -uq_ext[a] : uq_ext[a];
         end
      end
   end

   // ---------------- distortion polynomial ----------------
   logic signed [59:0] uu_p_ff, vv_p_ff, uv_p_ff;
   logic signed [29:0] uu_ff, vv_ff, uv_ff, uv2_ff;
   logic signed [30:0] r2_ff, r2b_ff, r2c_ff;
   logic signed [60:0] sum_uv2;
   logic signed [61:0] r2sq_ff;
   logic signed [31:0] ru_ff, rv_ff, r4_ff;
   logic signed [63:0] p1uv_ff, p2ru_ff, p1rv_ff, p2uv_ff;
   logic signed [63:0] k1r2_ff, k2r4_ff, r4r2_ff, k1r2b_ff, k2r4b_ff;
   logic signed [63:0] k3r6_ff, part_ff, poly_sum;
   logic signed [32:0] r6_ff;
   logic signed [63:0] tu_sum, tv_sum;
   logic signed [37:0] tvec_ff [pdr_pkg::T_DELAY+1][2];
   logic signed [37:0] fac_ff;

   assign sum_uv2 = 61'(uu_p_ff) + 61'(vv_p_ff);
   assign tu_sum  = (p1uv_ff <<< 1) + p2ru_ff;
   assign tv_sum  = p1rv_ff + (p2uv_ff <<< 1);
   assign poly_sum = part_ff + k3r6_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         ucoord_ff[0] <= ucoord_in;
         for (int k = 1; k <= pdr_pkg::U_DELAY; k++) begin
            ucoord_ff[k] <= ucoord_ff[k-1];
         end
         uu_p_ff  <= ucoord_ff[0][0] * ucoord_ff[0][0];
         vv_p_ff  <= ucoord_ff[0][1] * ucoord_ff[0][1];
         uv_p_ff  <= ucoord_ff[0][0] * ucoord_ff[0][1];
         uu_ff    <= uu_p_ff[57:28];
         vv_ff    <= vv_p_ff[57:28];
         uv_ff    <= uv_p_ff[57:28];
         r2_ff    <= sum_uv2[58:28];
         r2sq_ff  <= r2_ff * r2_ff;
         ru_ff    <= 32'(r2_ff) + (32'(uu_ff) <<< 1);
         rv_ff    <= 32'(r2_ff) + (32'(vv_ff) <<< 1);
         uv2_ff   <= uv_ff;
         r2b_ff   <= r2_ff;
         r4_ff    <= r2sq_ff[59:28];
         p1uv_ff  <= 64'(p1_ff) * 64'(uv2_ff);
         p2ru_ff  <= 64'(p2_ff) * 64'(ru_ff);
         p1rv_ff  <= 64'(p1_ff) * 64'(rv_ff);
         p2uv_ff  <= 64'(p2_ff) * 64'(uv2_ff);
         r2c_ff   <= r2b_ff;
         k1r2_ff  <= 64'(k1_ff) * 64'(r2c_ff);
         k2r4_ff  <= 64'(k2_ff) * 64'(r4_ff);
         r4r2_ff  <= 64'(r4_ff) * 64'(r2c_ff);
         tvec_ff[0][0] <= 38'(tu_sum >>> 28);
         tvec_ff[0][1] <= 38'(tv_sum >>> 28);
         for (int k = 1; k <= pdr_pkg::T_DELAY; k++) begin
            tvec_ff[k] <= tvec_ff[k-1];
         end
         r6_ff    <= r4r2_ff[60:28];
         k1r2b_ff <= k1r2_ff;
         k2r4b_ff <= k2r4_ff;
         k3r6_ff  <= 64'(k3_ff) * 64'(r6_ff);
         part_ff  <= k1r2b_ff + k2r4b_ff;
         fac_ff   <= pdr_pkg::FAC_ONE + 38'(poly_sum >>> 28);
      end
   end

   // ---------------- apply factor, back to pixels, residual ----------------
   logic signed [49:0] ph_ff [2];
   logic signed [48:0] pl_ff [2];
   logic signed [67:0] full_prod [2];
   logic signed [67:0] ur_shift [2];
   logic signed [39:0] d_ff [2];
   logic signed [32:0] dc_ff [2];
   logic signed [32:0] dc_in [2];
   logic signed [64:0] pp_ff [2];
   logic signed [64:0] pp_shift [2];
   logic signed [39:0] res_ff [2];
   logic signed [31:0] out_ff [2];
   logic signed [31:0] out_in [2];
   logic signed [31:0] obs [2];
   logic               d_clip [2];
   logic               r_clip [2];

   always_comb begin
      obs[0] = side_ff[pdr_pkg::ST_OUT-2].obs_u;
      obs[1] = side_ff[pdr_pkg::ST_OUT-2].obs_v;
      for (int a = 0; a < 2; a++) begin
         full_prod[a] = (68'(ph_ff[a]) <<< 18) + 68'(pl_ff[a]);
         ur_shift[a]  = full_prod[a] >>> 28;
         pp_shift[a]  = pp_ff[a] >>> 27;
         if (d_ff[a] > pdr_pkg::D_LIMIT) begin
            dc_in[a]  = 33'(pdr_pkg::D_LIMIT);
            d_clip[a] = 1'b1;
         end else if (d_ff[a] < -pdr_pkg::D_LIMIT) begin
            dc_in[a]  = 33'(-pdr_pkg::D_LIMIT);
            d_clip[a] = 1'b1;
         end else begin
            dc_in[a]  = 33'(d_ff[a]);
            d_clip[a] = 1'b0;
         end
         if (res_ff[a] > pdr_pkg::RES_MAX) begin
            out_in[a] = 32'(pdr_pkg::RES_MAX);
            r_clip[a] = 1'b1;
         end else if (res_ff[a] < pdr_pkg::RES_MIN) begin
            out_in[a] = 32'(pdr_pkg::RES_MIN);
            r_clip[a] = 1'b1;
         end else begin
            out_in[a] = 32'(res_ff[a]);
            r_clip[a] = 1'b0;
         end
      end
      d_sat = d_clip[0] | d_clip[1];
      r_sat = r_clip[0] | r_clip[1];
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int a = 0; a < 2; a++) begin
            // factor split in two narrow products, joined in the next stage
            ph_ff[a]  <= ucoord_ff[pdr_pkg::U_DELAY][a] * $signed(fac_ff[37:18]);
            pl_ff[a]  <= ucoord_ff[pdr_pkg::U_DELAY][a] * $signed({1'b0, fac_ff[17:0]});
            d_ff[a]   <= 40'(ur_shift[a]) + 40'(tvec_ff[pdr_pkg::T_DELAY][a]);
            dc_ff[a]  <= dc_in[a];
            pp_ff[a]  <= 65'(dc_ff[a]) * $signed({34'd0, center_ff[a]});
            res_ff[a] <= 40'(pp_shift[a]) + $signed({9'd0, center_ff[a]}) - 40'(obs[a]);
            out_ff[a] <= out_in[a];
         end
      end
   end

   assign rsp_tdata = {out_ff[1], out_ff[0]};
   assign rsp_tuser = {side_ff[pdr_pkg::ST_OUT].sat, side_ff[pdr_pkg::ST_OUT].depth_zero};

   // ---------------- assertions ----------------
   a_unit_range: assert property (@(posedge clock) disable iff (reset)
      vld_ff[pdr_pkg::ST_UNIT] |-> (ucoord_ff[0][0] <= pdr_pkg::UNIT_ONE &&
                                    ucoord_ff[0][0] >= -pdr_pkg::UNIT_ONE))
      else $error("normalised u outside [-1, 1]");

   a_div1_rem: assert property (@(posedge clock) disable iff (reset)
      (vld_ff[pdr_pkg::ST_PIX-1] && !side_ff[pdr_pkg::ST_PIX-1].depth_zero &&
       !d1_big_ff[D1][0]) |-> (d1_rem_ff[D1][0] < d1_div_ff[D1]))
      else $error("projection divider remainder not below divisor");

   a_div2_rem: assert property (@(posedge clock) disable iff (reset)
      (vld_ff[pdr_pkg::ST_UNIT-1] && center_ff[0] != 31'd0 && !d2_hi_ff[D2][0] &&
       !d2_lo_ff[D2][0]) |-> ({1'b0, d2_rem_ff[D2][0]} < {1'b0, center_ff[0]}))
      else $error("normalising divider remainder not below centre");

   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      !en |=> $stable(vld_ff))
      else $error("pipeline moved while stalled");

endmodule

`default_nettype wire
